// ===== hdl/chm_pkg.sv =====
// ---------------------------------------------------------------------------
// chm_pkg: shared types and constants of the chained hash map
// Sizes of the bucket and node stores, the item record and the back-end states.
// ---------------------------------------------------------------------------
package chm_pkg;

    localparam int MAX_BUCKETS = 1024;
    localparam int NODE_COUNT  = 1024;
    localparam int BW          = $clog2(MAX_BUCKETS);   // bucket index width
    localparam int NW          = $clog2(NODE_COUNT);    // node index width
    localparam int PTR_W       = NW + 1;                // node pointer incl. null
    localparam logic [PTR_W-1:0] NIL = PTR_W'(NODE_COUNT);

    // Clearing sweep covers the larger of the two stores.
    localparam int CLR_N = (MAX_BUCKETS > NODE_COUNT) ? MAX_BUCKETS : NODE_COUNT;
    localparam int CLR_W = $clog2(CLR_N);

    // Remainder unit: four quotient bits per cycle over a 32-bit sum.
    localparam int SUM_W     = 32;
    localparam int DIV_BITS  = 4;
    localparam int DIV_STEPS = SUM_W / DIV_BITS;
    localparam int DIV_CW    = $clog2(DIV_STEPS);

    localparam int BC_W = 11;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_SEARCH = 2'd1,
        OP_DELETE = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef struct packed {
        logic [1:0]    op;
        logic [14:0]   pid;
        logic [31:0]   vaddr;
        logic [15:0]   value;
        logic [BW-1:0] bucket;
    } t_item;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD,
        ST_INS,
        ST_HEAD,
        ST_CHK,
        ST_CMP,
        ST_FREE
    } t_back_state;

endpackage

// ===== hdl/chm_front.sv =====
// ---------------------------------------------------------------------------
// chm_front: item intake and bucket hashing
// Accepts an item, forms (vaddr + pid) mod bucket_count with a four-bit-per-
// cycle remainder unit and hands the classified item to the queue.
// ---------------------------------------------------------------------------
module chm_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [chm_pkg::BC_W-1:0] i_bucket_count,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [1:0]               i_op,
    input  logic [14:0]              i_pid,
    input  logic [31:0]              i_vaddr,
    input  logic [15:0]              i_value,
    output logic                     o_push,
    output chm_pkg::t_item           o_item,
    input  logic                     i_full
);

    logic                       r_busy, n_busy;
    logic                       r_done, n_done;
    logic [chm_pkg::DIV_CW-1:0] r_cnt, n_cnt;
    logic [chm_pkg::SUM_W-1:0]  r_sum, n_sum;
    logic [chm_pkg::BW:0]       r_m, n_m;
    logic [chm_pkg::BW-1:0]     r_rem, n_rem;
    chm_pkg::t_item             r_item, n_item;
    logic [chm_pkg::BW:0]       m_clamp;
    logic [chm_pkg::BW:0]       rem_step;
    logic                       accept;

    assign o_ready = !r_busy && !r_done;
    assign accept  = i_valid && o_ready;
    assign o_push  = r_done && !i_full;

    // Bucket count as used: zero acts as one, large values saturate.
    always_comb begin
        if (i_bucket_count == '0) begin
            m_clamp = (chm_pkg::BW+1)'(1);
        end else if (32'(i_bucket_count) > chm_pkg::MAX_BUCKETS) begin
            m_clamp = (chm_pkg::BW+1)'(chm_pkg::MAX_BUCKETS);
        end else begin
            m_clamp = (chm_pkg::BW+1)'(i_bucket_count);
        end
    end

    // Restoring remainder, most significant bits first.
    always_comb begin
        n_busy   = r_busy;
        n_done   = r_done;
        n_cnt    = r_cnt;
        n_sum    = r_sum;
        n_m      = r_m;
        n_rem    = r_rem;
        n_item   = r_item;
        rem_step = {1'b0, r_rem};
        if (accept) begin
            n_busy       = 1'b1;
            n_cnt        = '0;
            n_sum        = i_vaddr + chm_pkg::SUM_W'(i_pid);
            n_m          = m_clamp;
            n_rem        = '0;
            n_item.op    = i_op;
            n_item.pid   = i_pid;
            n_item.vaddr = i_vaddr;
            n_item.value = i_value;
        end else if (r_busy) begin
            for (int k = 0; k < chm_pkg::DIV_BITS; k++) begin
                rem_step = {rem_step[chm_pkg::BW-1:0], r_sum[chm_pkg::SUM_W-1-k]};
                if (rem_step >= r_m) begin
                    rem_step = rem_step - r_m;
                end
            end
            n_rem = rem_step[chm_pkg::BW-1:0];
            n_sum = r_sum << chm_pkg::DIV_BITS;
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == chm_pkg::DIV_CW'(chm_pkg::DIV_STEPS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end else if (o_push) begin
            n_done = 1'b0;
        end
        n_item.bucket = n_rem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_sum  <= n_sum;
        r_m    <= n_m;
        r_rem  <= n_rem;
        r_item <= n_item;
    end

    assign o_item = r_item;

endmodule

// ===== hdl/chm_fifo.sv =====
// ---------------------------------------------------------------------------
// chm_fifo: two-entry item queue
// Decouples the hashing front end from the chain-walking back end.
// ---------------------------------------------------------------------------
module chm_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  chm_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output chm_pkg::t_item o_item
);

    chm_pkg::t_item r_mem [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;
    logic           do_push, do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;
    assign o_item  = r_mem[r_rp];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wp <= !r_wp;
            end
            if (do_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

// ===== hdl/chm_back.sv =====
// ---------------------------------------------------------------------------
// chm_back: chain store and operation sequencer
// Holds bucket heads, node records and the free list, carries out insert,
// search and delete, and keeps the result register.
// ---------------------------------------------------------------------------
module chm_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  chm_pkg::t_item i_q_item,
    output logic           o_q_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output logic           o_found,
    output logic [15:0]    o_result_value,
    output logic           o_pool_empty
);

    localparam int NW    = chm_pkg::NW;
    localparam int BW    = chm_pkg::BW;
    localparam int PTR_W = chm_pkg::PTR_W;

    // Memories.
    logic [PTR_W-1:0] m_bhead [chm_pkg::MAX_BUCKETS];
    logic [PTR_W-1:0] m_next  [chm_pkg::NODE_COUNT];
    logic [14:0]      m_pid   [chm_pkg::NODE_COUNT];
    logic [31:0]      m_addr  [chm_pkg::NODE_COUNT];
    logic [15:0]      m_val   [chm_pkg::NODE_COUNT];

    logic [PTR_W-1:0] q_bhead, q_next;
    logic [14:0]      q_pid;
    logic [31:0]      q_addr;
    logic [15:0]      q_val;

    chm_pkg::t_back_state r_state, n_state;
    chm_pkg::t_item       r_item;
    logic [chm_pkg::CLR_W-1:0] r_clr;
    logic [PTR_W-1:0]     r_cur, r_prev, r_free;
    logic                 r_ovalid, r_found, r_empty;
    logic [15:0]          r_rv;

    logic             match, clr_last;
    logic             bh_we, nx_we, rec_we;
    logic [BW-1:0]    bh_wa;
    logic [PTR_W-1:0] bh_wd;
    logic [NW-1:0]    nx_wa, nd_ra;
    logic [PTR_W-1:0] nx_wd;
    logic             fin, fin_found, fin_empty;
    logic [15:0]      fin_rv;
    logic             ld_cur_head, ld_walk, ld_free_next, ld_free_cur;

    assign match    = (q_pid == r_item.pid) && (q_addr == r_item.vaddr);
    assign clr_last = (r_clr == chm_pkg::CLR_W'(chm_pkg::CLR_N - 1));

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            chm_pkg::ST_CLEAR: begin
                if (clr_last) begin
                    n_state = chm_pkg::ST_IDLE;
                end
            end
            chm_pkg::ST_IDLE: begin
                if (i_q_valid && !r_ovalid) begin
                    n_state = chm_pkg::ST_LOAD;
                end
            end
            chm_pkg::ST_LOAD: begin
                case (r_item.op)
                    chm_pkg::OP_INSERT: begin
                        n_state = (r_free == chm_pkg::NIL) ? chm_pkg::ST_IDLE
                                                           : chm_pkg::ST_INS;
                    end
                    chm_pkg::OP_SEARCH, chm_pkg::OP_DELETE: n_state = chm_pkg::ST_HEAD;
                    default: n_state = chm_pkg::ST_IDLE;
                endcase
            end
            chm_pkg::ST_INS:  n_state = chm_pkg::ST_IDLE;
            chm_pkg::ST_HEAD: n_state = chm_pkg::ST_CHK;
            chm_pkg::ST_CHK: begin
                n_state = (r_cur == chm_pkg::NIL) ? chm_pkg::ST_IDLE : chm_pkg::ST_CMP;
            end
            chm_pkg::ST_CMP: begin
                if (!match) begin
                    n_state = chm_pkg::ST_CHK;
                end else if (r_item.op == chm_pkg::OP_DELETE) begin
                    n_state = chm_pkg::ST_FREE;
                end else begin
                    n_state = chm_pkg::ST_IDLE;
                end
            end
            chm_pkg::ST_FREE: n_state = chm_pkg::ST_IDLE;
            default: n_state = chm_pkg::ST_IDLE;
        endcase
    end

    // Outputs: memory ports, pointer loads and result.
    always_comb begin
        o_q_pop      = 1'b0;
        bh_we        = 1'b0;
        bh_wa        = r_item.bucket;
        bh_wd        = r_free;
        nx_we        = 1'b0;
        nx_wa        = r_free[NW-1:0];
        nx_wd        = q_bhead;
        rec_we       = 1'b0;
        nd_ra        = r_free[NW-1:0];
        fin          = 1'b0;
        fin_found    = 1'b0;
        fin_rv       = '0;
        fin_empty    = 1'b0;
        ld_cur_head  = 1'b0;
        ld_walk      = 1'b0;
        ld_free_next = 1'b0;
        ld_free_cur  = 1'b0;
        case (r_state)
            chm_pkg::ST_CLEAR: begin
                bh_we = (32'(r_clr) < chm_pkg::MAX_BUCKETS);
                bh_wa = r_clr[BW-1:0];
                bh_wd = chm_pkg::NIL;
                nx_we = (32'(r_clr) < chm_pkg::NODE_COUNT);
                nx_wa = r_clr[NW-1:0];
                nx_wd = PTR_W'(r_clr) + 1'b1;
            end
            chm_pkg::ST_IDLE: begin
                o_q_pop = i_q_valid && !r_ovalid;
            end
            chm_pkg::ST_LOAD: begin
                case (r_item.op)
                    chm_pkg::OP_INSERT: begin
                        if (r_free == chm_pkg::NIL) begin
                            fin       = 1'b1;
                            fin_empty = 1'b1;
                        end
                    end
                    chm_pkg::OP_SEARCH, chm_pkg::OP_DELETE: begin
                    end
                    default: fin = 1'b1;
                endcase
            end
            chm_pkg::ST_INS: begin
                // New node goes to the head of its bucket's chain.
                rec_we       = 1'b1;
                nx_we        = 1'b1;
                bh_we        = 1'b1;
                ld_free_next = 1'b1;
                fin          = 1'b1;
            end
            chm_pkg::ST_HEAD: begin
                ld_cur_head = 1'b1;
            end
            chm_pkg::ST_CHK: begin
                nd_ra = r_cur[NW-1:0];
                if (r_cur == chm_pkg::NIL) begin
                    fin = 1'b1;
                end
            end
            chm_pkg::ST_CMP: begin
                if (!match) begin
                    ld_walk = 1'b1;
                end else if (r_item.op == chm_pkg::OP_DELETE) begin
                    // Unlink the node from its predecessor or the bucket head.
                    if (r_prev == chm_pkg::NIL) begin
                        bh_we = 1'b1;
                        bh_wd = q_next;
                    end else begin
                        nx_we = 1'b1;
                        nx_wa = r_prev[NW-1:0];
                        nx_wd = q_next;
                    end
                end else begin
                    fin       = 1'b1;
                    fin_found = 1'b1;
                    fin_rv    = q_val;
                end
            end
            chm_pkg::ST_FREE: begin
                nx_we       = 1'b1;
                nx_wa       = r_cur[NW-1:0];
                nx_wd       = r_free;
                ld_free_cur = 1'b1;
                fin         = 1'b1;
                fin_found   = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Memory ports with registered reads.
    always_ff @(posedge i_clk) begin
        if (bh_we) begin
            m_bhead[bh_wa] <= bh_wd;
        end
        if (nx_we) begin
            m_next[nx_wa] <= nx_wd;
        end
        if (rec_we) begin
            m_pid[r_free[NW-1:0]]  <= r_item.pid;
            m_addr[r_free[NW-1:0]] <= r_item.vaddr;
            m_val[r_free[NW-1:0]]  <= r_item.value;
        end
        q_bhead <= m_bhead[r_item.bucket];
        q_next  <= m_next[nd_ra];
        q_pid   <= m_pid[nd_ra];
        q_addr  <= m_addr[nd_ra];
        q_val   <= m_val[nd_ra];
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= chm_pkg::ST_CLEAR;
            r_clr    <= '0;
            r_free   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == chm_pkg::ST_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (ld_free_next) begin
                r_free <= q_next;
            end else if (ld_free_cur) begin
                r_free <= r_cur;
            end
            if (fin) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Item, walk pointers and result payload.
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_item <= i_q_item;
        end
        if (ld_cur_head) begin
            r_cur  <= q_bhead;
            r_prev <= chm_pkg::NIL;
        end else if (ld_walk) begin
            r_prev <= r_cur;
            r_cur  <= q_next;
        end
        if (fin) begin
            r_found <= fin_found;
            r_rv    <= fin_rv;
            r_empty <= fin_empty;
        end
    end

    assign o_valid        = r_ovalid;
    assign o_found        = r_found;
    assign o_result_value = r_rv;
    assign o_pool_empty   = r_empty;

    // A result is only produced into an empty result register.
    a_fin_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fin |-> !r_ovalid) else $error("result overwrites a pending result");

    // A freed node is a real node.
    a_free_node: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == chm_pkg::ST_FREE) |-> (r_cur != chm_pkg::NIL))
        else $error("freeing the null node");

    // The free list head is a node or null.
    a_free_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free <= chm_pkg::NIL) else $error("free list head out of range");

    // No item is taken during the clearing sweep.
    a_no_pop_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == chm_pkg::ST_CLEAR) |-> !o_q_pop)
        else $error("item taken while clearing");

endmodule

// ===== hdl/chained_hash_map_pid_vaddr.sv =====
// ---------------------------------------------------------------------------
// chained_hash_map_pid_vaddr: (pid, vaddr) to frame index hash map
// Separate chaining over a fixed node pool with a LIFO free list.
// ---------------------------------------------------------------------------
// Items enter on the s_axis channel: each is an insert, search or delete of
// a (pid, vaddr) key. Every item gives exactly one result on m_axis: found,
// the stored value on a search hit, and pool_empty when an insert finds no
// free node. The bucket count must be written on the cfg channel only while
// idle; the block itself does not enforce it. The front end forms the bucket
// with a remainder unit and hands the item on to the queue; it then takes the
// next item while the back end works. The back end pops an item in IDLE and
// decodes it in LOAD; an insert writes its node in INS, while a search or
// delete reads the chain head in HEAD, then visits each node in CHK and CMP
// as memory reads are registered; a delete hit frees the node in FREE.
// After reset the back end sweeps its bucket heads and free-list links; items
// wait in the queue meanwhile and no result is produced. A stalled receiver
// holds the result; the back end then waits and the front end keeps filling
// its two-entry queue until that too is full.
// ---------------------------------------------------------------------------
module chained_hash_map_pid_vaddr (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // op[1:0], pid[16:2], vaddr[48:17], value[64:49], zero fill
    input  logic [71:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // found[0], result_value[16:1], pool_empty[17], zero fill
    output logic [23:0] m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [10:0] i_cfg_data
);

    logic [chm_pkg::BC_W-1:0] r_bucket_count;
    logic                     push, full, q_valid, pop;
    chm_pkg::t_item           f_item, q_item;
    logic                     found, pool_empty;
    logic [15:0]              result_value;

    // Bucket count register.
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bucket_count <= 11'd1021;
        end else if (i_cfg_valid) begin
            r_bucket_count <= i_cfg_data;
        end
    end

    chm_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_bucket_count (r_bucket_count),
        .i_valid        (s_axis_tvalid),
        .o_ready        (s_axis_tready),
        .i_op           (s_axis_tdata[1:0]),
        .i_pid          (s_axis_tdata[16:2]),
        .i_vaddr        (s_axis_tdata[48:17]),
        .i_value        (s_axis_tdata[64:49]),
        .o_push         (push),
        .o_item         (f_item),
        .i_full         (full)
    );

    chm_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (f_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    chm_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_q_item       (q_item),
        .o_q_pop        (pop),
        .o_valid        (m_axis_tvalid),
        .i_ready        (m_axis_tready),
        .o_found        (found),
        .o_result_value (result_value),
        .o_pool_empty   (pool_empty)
    );

    assign m_axis_tdata = {6'd0, pool_empty, result_value, found};

endmodule
